/* rtl/core/weighted_rgba_blend_top_assert.svh */
// Assertion macros used by the weighted RGBA blend top level.
`ifndef WEIGHTED_RGBA_BLEND_TOP_ASSERT_SVH
`define WEIGHTED_RGBA_BLEND_TOP_ASSERT_SVH

// Same-cycle implication, clocked on clk and disabled while arst_n is low.
`define WRB_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk and disabled while arst_n is low.
`define WRB_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/wrb_pkg.sv */
// Types and constants shared by the weighted RGBA blend modules.
package wrb_pkg;

	localparam int ChanW    = 8;
	localparam int NumLanes = 4;
	localparam int WeightW  = 16;
	localparam int MagW     = WeightW - 1;
	localparam int ProdW    = ChanW + MagW;
	localparam int SumW     = ProdW + 1;
	localparam int DivW     = MagW + 1;
	localparam int QuoW     = ChanW;
	localparam int DivSteps = QuoW;
	localparam int Lat      = DivSteps + 2;

	typedef logic [ChanW-1:0]                chan_t;
	typedef logic [NumLanes-1:0][ChanW-1:0]  colour_t;
	typedef logic [MagW-1:0]                 mag_t;
	typedef logic [ProdW-1:0]                prod_t;
	typedef logic [SumW-1:0]                 sum_t;
	typedef logic [DivW-1:0]                 div_t;
	typedef logic [QuoW-1:0]                 quo_t;

	// What the result of one word is made of.
	typedef enum logic [1:0] {
		KIND_FIRST  = 2'd0,
		KIND_SECOND = 2'd1,
		KIND_BLEND  = 2'd2
	} kind_t;

endpackage

/* rtl/core/wrb_lane.sv */
// One channel lane: weighted sum and a pipelined restoring divider, one quotient bit per stage.
module wrb_lane
	import wrb_pkg::*;
(
	input  logic                    clk,
	input  logic                    en,
	input  chan_t                   first_chan,
	input  chan_t                   second_chan,
	input  mag_t                    first_mag,
	input  mag_t                    second_mag,
	input  div_t [DivSteps-1:0]     divisor,
	output quo_t                    quotient
);

	prod_t prod_a_s1;
	prod_t prod_b_s1;
	sum_t  sum_s2;

	// Stage k of the divider sits at pipeline stage k+3.
	sum_t  rem_s [DivSteps-1];
	quo_t  quo_s [DivSteps];
	sum_t  step_num [DivSteps];
	quo_t  step_quo [DivSteps];

	always_ff @(posedge clk) begin
		if (en) begin
			prod_a_s1 <= ProdW'(first_chan) * ProdW'(first_mag);
			prod_b_s1 <= ProdW'(second_chan) * ProdW'(second_mag);
			sum_s2    <= SumW'(prod_a_s1) + SumW'(prod_b_s1);
		end
	end

	assign step_num[0] = sum_s2;
	assign step_quo[0] = '0;

	for (genvar i = 0; i < DivSteps; i++) begin : g_step
		localparam int Shift = DivSteps - 1 - i;
		sum_t trial;
		logic fits;

		if (i > 0) begin : g_link
			assign step_num[i] = rem_s[i-1];
			assign step_quo[i] = quo_s[i-1];
		end

		assign trial = SumW'(divisor[i]) << Shift;
		assign fits  = step_num[i] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				quo_s[i] <= step_quo[i] | (fits ? (QuoW'(1) << Shift) : '0);
			end
		end

		if (i < DivSteps - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[i] <= fits ? step_num[i] - trial : step_num[i];
				end
			end
		end
	end

	assign quotient = quo_s[DivSteps-1];

endmodule

/* rtl/core/wrb_merge.sv */
// Merging stage: picks a pass-through color or the lane quotients for the output word.
module wrb_merge
	import wrb_pkg::*;
(
	input  kind_t                  kind,
	input  colour_t                first_colour,
	input  colour_t                second_colour,
	input  quo_t [NumLanes-1:0]    quotients,
	output colour_t                mixed
);

	always_comb begin
		case (kind)
			KIND_FIRST:  mixed = first_colour;
			KIND_SECOND: mixed = second_colour;
			KIND_BLEND: begin
				for (int i = 0; i < NumLanes; i++) begin
					mixed[i] = chan_t'(quotients[i]);
				end
			end
			default:     mixed = first_colour;
		endcase
	end

endmodule

/* rtl/core/weighted_rgba_blend_top.sv */
// Top level of the weighted RGBA blend: stream ports, shared control pipeline and four lanes.
//
// Weighted RGBA blend. Each input word carries two RGBA colors (8 bits per
// channel) and two signed 16-bit weights; each output word carries one color
// whose channels are (c1*w1 + c2*w2) / (w1 + w2), truncated. If the second
// weight is zero or negative the first color passes through unchanged;
// otherwise, if the first weight is zero or negative, the second color passes
// through. The block accepts one word every clock cycle unless a stalled output
// holds it, and returns results in order: the two products are registered, then
// their sum, then the divider, which resolves one quotient bit per
// pipeline stage. The whole pipeline advances together whenever the output
// register is empty or being taken, so s_axis_tready follows m_axis_tready
// combinationally and a stalled output holds every stage. Reset clears only
// the valid bits; the block has no configuration and no state between words.
module weighted_rgba_blend_top
	import wrb_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// From bit 0: first_red, first_green, first_blue, first_alpha, second_red,
	// second_green, second_blue, second_alpha (8 bits each), first_weight,
	// second_weight (16 bits each, two's complement).
	input  logic [95:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// From bit 0: mixed_red, mixed_green, mixed_blue, mixed_alpha (8 bits each).
	output logic [31:0]  m_axis_tdata
);

	`include "weighted_rgba_blend_top_assert.svh"

	// Field slices of the input word.
	colour_t                in_first;
	colour_t                in_second;
	logic [WeightW-1:0]     in_w1;
	logic [WeightW-1:0]     in_w2;
	logic                   w1_pos;
	logic                   w2_pos;
	kind_t                  in_kind;

	// Global advance: every stage moves when the output register can take a word.
	logic                   adv;

	// Control and pass-through pipeline, indexed by stage.
	logic                   vld_s  [1:Lat];
	kind_t                  kind_s [1:Lat];
	colour_t                col1_s [1:Lat];
	colour_t                col2_s [1:Lat];
	div_t                   div_s  [1:Lat-1];

	div_t [DivSteps-1:0]    lane_div;
	quo_t [NumLanes-1:0]    lane_quo;
	colour_t                mixed;

	assign in_first  = s_axis_tdata[31:0];
	assign in_second = s_axis_tdata[63:32];
	assign in_w1     = s_axis_tdata[79:64];
	assign in_w2     = s_axis_tdata[95:80];

	// A weight counts as positive when its sign bit is clear and it is not zero.
	assign w1_pos = !in_w1[WeightW-1] && (in_w1 != '0);
	assign w2_pos = !in_w2[WeightW-1] && (in_w2 != '0);

	// The second weight is checked first.
	always_comb begin
		if (!w2_pos) begin
			in_kind = KIND_FIRST;
		end else if (!w1_pos) begin
			in_kind = KIND_SECOND;
		end else begin
			in_kind = KIND_BLEND;
		end
	end

	assign adv           = m_axis_tready || !vld_s[Lat];
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_s[Lat];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= Lat; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (adv) begin
			vld_s[1] <= s_axis_tvalid;
			for (int i = 2; i <= Lat; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	// Payload needs no reset; only the valid bits above qualify it.
	always_ff @(posedge clk) begin
		if (adv) begin
			kind_s[1] <= in_kind;
			col1_s[1] <= in_first;
			col2_s[1] <= in_second;
			// Both weights are below 2^15 when this divisor is used, so it cannot overflow.
			div_s[1]  <= DivW'(in_w1[MagW-1:0]) + DivW'(in_w2[MagW-1:0]);
			for (int i = 2; i <= Lat; i++) begin
				kind_s[i] <= kind_s[i-1];
				col1_s[i] <= col1_s[i-1];
				col2_s[i] <= col2_s[i-1];
			end
			for (int i = 2; i <= Lat - 1; i++) begin
				div_s[i] <= div_s[i-1];
			end
		end
	end

	// Divider step k of every lane uses the divisor that travels at stage k+2.
	for (genvar k = 0; k < DivSteps; k++) begin : g_div
		assign lane_div[k] = div_s[k+2];
	end

	for (genvar l = 0; l < NumLanes; l++) begin : g_lane
		wrb_lane u_lane (
			.clk         (clk),
			.en          (adv),
			.first_chan  (in_first[l]),
			.second_chan (in_second[l]),
			.first_mag   (in_w1[MagW-1:0]),
			.second_mag  (in_w2[MagW-1:0]),
			.divisor     (lane_div),
			.quotient    (lane_quo[l])
		);
	end

	wrb_merge u_merge (
		.kind          (kind_s[Lat]),
		.first_colour  (col1_s[Lat]),
		.second_colour (col2_s[Lat]),
		.quotients     (lane_quo),
		.mixed         (mixed)
	);

	assign m_axis_tdata = mixed;

	// A held output word must stall the input side.
	`WRB_ASSERT_IMP(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input accepted while output stalled")
	// An accepted word enters the first stage.
	`WRB_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld_s[1], "accepted word lost at entry")
	// A blended word always carries a divisor of at least two.
	`WRB_ASSERT_IMP(a_blend_divisor, vld_s[1] && (kind_s[1] == KIND_BLEND), div_s[1] >= DivW'(2), "blend word with too small a divisor")

endmodule

/* tb/weighted_rgba_blend_top_tb.sv */
// Self-checking stream testbench for the weighted RGBA blend top level.
`timescale 1ns / 1ps

module weighted_rgba_blend_top_tb;
	import wrb_pkg::*;

	// Run limit in cycles.
	localparam int unsigned CycleLimit = 200000;
	localparam int MaxReported = 10;

	// One input word as it sits on s_axis_tdata, lowest field last in the list.
	typedef struct packed {
		logic signed [15:0] second_weight;
		logic signed [15:0] first_weight;
		colour_t            second_colour;
		colour_t            first_colour;
	} pair_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [95:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;

	// Blended colours still owed by the block, oldest first.
	colour_t     pending_mix[$];
	int unsigned fault_count = 0;
	int unsigned blend_count = 0;

	// Idling control shared by sender and receiver.
	bit          idling_on = 1'b1;
	int unsigned burst_left = 0;
	logic [15:0] ready_pattern = 16'hffff;
	int unsigned ready_phase = 0;

	string lane_name[NumLanes] = '{"mixed_red", "mixed_green", "mixed_blue", "mixed_alpha"};

	weighted_rgba_blend_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Expected blend of one word: the guards on the second weight come first.
	function automatic colour_t blend_colour(pair_word_t w);
		colour_t     mix;
		int unsigned wa;
		int unsigned wb;
		int unsigned num;
		if (w.second_weight <= 0)
			return w.first_colour;
		if (w.first_weight <= 0)
			return w.second_colour;
		wa = w.first_weight;
		wb = w.second_weight;
		for (int i = 0; i < NumLanes; i++) begin
			num = w.first_colour[i] * wa + w.second_colour[i] * wb;
			mix[i] = chan_t'(num / (wa + wb));
		end
		return mix;
	endfunction

	function automatic colour_t rgba(chan_t r, chan_t g, chan_t b, chan_t a);
		return {a, b, g, r};
	endfunction

	// Channels lean toward the extremes now and then so saturated values show up.
	function automatic chan_t pick_channel();
		case ($urandom_range(0, 9))
			0: return 8'h00;
			1: return 8'hff;
			default: return chan_t'($urandom());
		endcase
	endfunction

	// Weights are mostly positive so the divider gets real work; the rest hit the guards.
	function automatic logic signed [15:0] pick_weight();
		case ($urandom_range(0, 19))
			0: return 16'sd0;
			1: return -16'sd1;
			2: return 16'sh8000;
			3: return 16'sh7fff;
			4: return 16'sd1;
			5, 6: return 16'sh8000 | 16'($urandom());
			7, 8, 9: return 16'($urandom_range(1, 16));
			default: return 16'($urandom_range(1, 32767));
		endcase
	endfunction

	// Sends one word; valid only drops when a gap between bursts is taken.
	task automatic send_pair(pair_word_t w);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = idling_on ? $urandom_range(0, 6) : 0;
			if (gap != 0) begin
				@(negedge clk);
				s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= w;
		do @(posedge clk); while (!s_axis_tready);
		if (idling_on)
			burst_left--;
	endtask

	task automatic send_case(colour_t c1, colour_t c2, logic signed [15:0] w1,
				 logic signed [15:0] w2);
		pair_word_t w;
		w.first_colour  = c1;
		w.second_colour = c2;
		w.first_weight  = w1;
		w.second_weight = w2;
		send_pair(w);
	endtask

	task automatic send_random_pair();
		colour_t c1;
		colour_t c2;
		for (int i = 0; i < NumLanes; i++) begin
			c1[i] = pick_channel();
			c2[i] = pick_channel();
		end
		send_case(c1, c2, pick_weight(), pick_weight());
	endtask

	// Drops valid and holds off until the block has returned everything.
	task automatic wait_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (pending_mix.size() != 0) @(posedge clk);
	endtask

	// Pass-through cases: the second weight guard wins over the first.
	task automatic test_guard_order();
		colour_t c1;
		colour_t c2;
		c1 = rgba(8'h12, 8'h34, 8'h56, 8'h78);
		c2 = rgba(8'h9a, 8'hbc, 8'hde, 8'hf0);
		send_case(c1, c2, 16'sd100, 16'sd0);
		send_case(c1, c2, 16'sd100, -16'sd1);
		send_case(c1, c2, 16'sh7fff, 16'sh8000);
		send_case(c1, c2, 16'sd0, 16'sd0);
		send_case(c1, c2, 16'sh8000, 16'sh8000);
		send_case(c1, c2, -16'sd1, -16'sd5);
		send_case(c1, c2, 16'sd0, 16'sd7);
		send_case(c1, c2, -16'sd1, 16'sd1);
		send_case(c1, c2, 16'sh8000, 16'sh7fff);
		send_case(rgba(8'hff, 8'hff, 8'hff, 8'hff), rgba(8'h00, 8'h00, 8'h00, 8'h00),
			  16'sh8000, -16'sd1);
	endtask

	// Weighted averages at the weight and channel extremes, plus the equal-weight halving case.
	task automatic test_weight_extremes();
		colour_t white;
		colour_t black;
		colour_t mixed;
		white = rgba(8'hff, 8'hff, 8'hff, 8'hff);
		black = rgba(8'h00, 8'h00, 8'h00, 8'h00);
		mixed = rgba(8'hff, 8'h00, 8'h80, 8'h01);
		send_case(white, black, 16'sh7fff, 16'sh7fff);
		send_case(white, white, 16'sh7fff, 16'sh7fff);
		send_case(black, black, 16'sd1, 16'sd1);
		send_case(white, black, 16'sd1, 16'sh7fff);
		send_case(black, white, 16'sd1, 16'sh7fff);
		send_case(white, black, 16'sh7fff, 16'sd1);
		send_case(mixed, white, 16'sd1, 16'sd1);
		send_case(rgba(8'hff, 8'h01, 8'h03, 8'h00), rgba(8'hfe, 8'h00, 8'h00, 8'h01),
			  16'sd1, 16'sd1);
		send_case(mixed, black, 16'sd3, 16'sd2);
		send_case(white, mixed, 16'sh4000, 16'sh3fff);
		send_case(black, mixed, 16'sd2, 16'sd3);
	endtask

	// Full rate: no sender gaps and no receiver stalls.
	task automatic test_back_to_back(int unsigned count);
		idling_on  = 1'b0;
		burst_left = 0;
		repeat (count) send_random_pair();
		wait_drained();
		idling_on = 1'b1;
	endtask

	// Random words with idling on both sides, pausing for a full drain midway.
	task automatic test_random_blend(int unsigned count);
		for (int unsigned n = 0; n < count; n++) begin
			send_random_pair();
			if (n == count / 2)
				wait_drained();
		end
	endtask

	// Receiver: a 16-bit ready pattern, redrawn every period, never all stalls.
	always @(negedge clk) begin
		if (!idling_on) begin
			m_axis_tready <= 1'b1;
		end else begin
			if (ready_phase == 0) begin
				case ($urandom_range(0, 3))
					0: ready_pattern = 16'hffff;
					1: ready_pattern = 16'($urandom()) & 16'($urandom()) | 16'h0001;
					default: ready_pattern = 16'($urandom()) | 16'h0001;
				endcase
			end
			m_axis_tready <= ready_pattern[ready_phase];
			ready_phase = (ready_phase + 1) % 16;
		end
	end

	// Predicts on every accepted input word and checks every accepted output word.
	always @(posedge clk) begin : scoreboard
		colour_t want;
		colour_t got;
		bit      wrong;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				pending_mix.push_back(blend_colour(pair_word_t'(s_axis_tdata)));
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				if (pending_mix.size() == 0) begin
					fault_count++;
					if (fault_count <= MaxReported)
						$display("unexpected output word %h", got);
				end else begin
					want  = pending_mix.pop_front();
					wrong = 1'b0;
					for (int i = 0; i < NumLanes; i++) begin
						if (got[i] !== want[i]) begin
							wrong = 1'b1;
							if (fault_count < MaxReported)
								$display("word %0d %s: expected %h, got %h",
									 blend_count, lane_name[i], want[i], got[i]);
						end
					end
					if (wrong)
						fault_count++;
					blend_count++;
				end
			end
		end
	end

	initial begin
		repeat (CycleLimit) @(posedge clk);
		$display("weighted_rgba_blend_top test failed");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_guard_order();
		test_weight_extremes();
		test_back_to_back(120);
		test_random_blend(700);

		wait_drained();
		repeat (Lat + 6) @(posedge clk);
		if (pending_mix.size() != 0)
			fault_count++;
		if (fault_count == 0) begin
			$display("weighted_rgba_blend_top test passed");
		end else begin
			$display("weighted_rgba_blend_top test failed");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+rtl/core
rtl/core/wrb_pkg.sv
rtl/core/wrb_lane.sv
rtl/core/wrb_merge.sv
rtl/core/weighted_rgba_blend_top.sv
tb/weighted_rgba_blend_top_tb.sv
